### rtl/dque_pkg.sv
// Shared constants, operation codes and control types of the double-ended queue.
package dque_pkg;

    // Default ring capacity and fixed payload widths.
    localparam int DEPTH_DEFAULT = 16;
    localparam int KIND_W        = 3;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_capture;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_read;
        logic out_free;
    } t_dp_stat;

endpackage

### rtl/dque_in_if.sv
// Request channel of the double-ended queue.
interface dque_in_if;
    import dque_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

### rtl/dque_out_if.sv
// Result channel of the double-ended queue.
interface dque_out_if #(
    parameter int CNT_W = 5
);
    import dque_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;

    modport source (
        output valid, output status, output removed_value, output front_value,
        output back_value, output entry_count, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input removed_value, input front_value,
        input back_value, input entry_count, input is_empty, output ready
    );
endinterface

### rtl/dque_dp.sv
// Datapath of the double-ended queue: slot memory, ring pointers, end values, result register.
module dque_dp #(
    parameter  int DEPTH = dque_pkg::DEPTH_DEFAULT,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dque_pkg::t_dp_cmd                  i_cmd,
    output dque_pkg::t_dp_stat                 o_stat,
    input  logic [dque_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [dque_pkg::DATA_W-1:0] i_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [dque_pkg::STATUS_W-1:0]      o_status,
    output logic signed [dque_pkg::DATA_W-1:0] o_removed_value,
    output logic signed [dque_pkg::DATA_W-1:0] o_front_value,
    output logic signed [dque_pkg::DATA_W-1:0] o_back_value,
    output logic [CNT_W-1:0]                   o_entry_count,
    output logic                               o_is_empty
);
    import dque_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // Ring index steps with wrap at the capacity.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
    endfunction

    // Captured request.
    logic [KIND_W-1:0]        r_kind;
    logic signed [DATA_W-1:0] r_value;

    // Ring state: front index, next free slot at the back, entry count.
    logic [IDX_W-1:0] r_first, n_first;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;

    // Cached end values and per-request results.
    logic signed [DATA_W-1:0] r_front, n_front;
    logic signed [DATA_W-1:0] r_back, n_back;
    logic [STATUS_W-1:0]      r_status, n_status;
    logic signed [DATA_W-1:0] r_removed, n_removed;

    // Slot memory and its registered read port.
    logic signed [DATA_W-1:0] r_mem [DEPTH];
    logic signed [DATA_W-1:0] r_rd_data;
    logic                     r_rd_front, n_rd_front;
    logic                     n_need_read;
    logic                     w_wr_en;
    logic [IDX_W-1:0]         w_wr_addr;
    logic [IDX_W-1:0]         w_rd_addr;

    // Result register.
    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_o_status;
    logic signed [DATA_W-1:0] r_o_removed;
    logic signed [DATA_W-1:0] r_o_front;
    logic signed [DATA_W-1:0] r_o_back;
    logic [CNT_W-1:0]         r_o_count;

    logic w_full;
    logic w_empty;

    assign w_full  = (r_count == FULL_CNT);
    assign w_empty = (r_count == '0);

    // Capture the request on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
    end

    // Next ring state, memory access and results for the captured request.
    always_comb begin
        n_first     = r_first;
        n_tail      = r_tail;
        n_count     = r_count;
        n_front     = r_front;
        n_back      = r_back;
        n_status    = STATUS_OK;
        n_removed   = '0;
        n_need_read = 1'b0;
        n_rd_front  = 1'b1;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_tail;
        w_rd_addr   = r_first;
        case (r_kind)
            KIND_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = STATUS_OVERFLOW;
                end else begin
                    n_first   = idx_dec(r_first);
                    w_wr_en   = 1'b1;
                    w_wr_addr = idx_dec(r_first);
                    n_count   = r_count + CNT_W'(1);
                    n_front   = r_value;
                    if (w_empty) begin
                        n_back = r_value;
                    end
                end
            end
            KIND_PUSH_BACK: begin
                if (w_full) begin
                    n_status = STATUS_OVERFLOW;
                end else begin
                    n_tail    = idx_inc(r_tail);
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_tail;
                    n_count   = r_count + CNT_W'(1);
                    n_back    = r_value;
                    if (w_empty) begin
                        n_front = r_value;
                    end
                end
            end
            KIND_POP_FRONT: begin
                if (w_empty) begin
                    n_status = STATUS_UNDERFLOW;
                end else begin
                    n_removed = r_front;
                    n_first   = idx_inc(r_first);
                    n_count   = r_count - CNT_W'(1);
                    // The new front comes from memory unless the queue drains.
                    if (r_count != CNT_W'(1)) begin
                        n_need_read = 1'b1;
                        n_rd_front  = 1'b1;
                        w_rd_addr   = idx_inc(r_first);
                    end
                end
            end
            KIND_POP_BACK: begin
                if (w_empty) begin
                    n_status = STATUS_UNDERFLOW;
                end else begin
                    n_removed = r_back;
                    n_tail    = idx_dec(r_tail);
                    n_count   = r_count - CNT_W'(1);
                    // The new back sits two slots before the old free slot.
                    if (r_count != CNT_W'(1)) begin
                        n_need_read = 1'b1;
                        n_rd_front  = 1'b0;
                        w_rd_addr   = idx_dec(idx_dec(r_tail));
                    end
                end
            end
            KIND_CLEAR: begin
                n_first = '0;
                n_tail  = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Ring pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_first <= n_first;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // End values, request results and the refill from the memory read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_front    <= n_front;
            r_back     <= n_back;
            r_status   <= n_status;
            r_removed  <= n_removed;
            r_rd_front <= n_rd_front;
        end else if (i_cmd.rd_capture) begin
            if (r_rd_front) begin
                r_front <= r_rd_data;
            end else begin
                r_back <= r_rd_data;
            end
        end
    end

    // Slot memory: at most one write and one registered read per request.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) begin
            r_mem[w_wr_addr] <= r_value;
        end
        if (i_cmd.exec) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; both end values read as zero when the queue is empty.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_status  <= r_status;
            r_o_removed <= r_removed;
            r_o_front   <= w_empty ? '0 : r_front;
            r_o_back    <= w_empty ? '0 : r_back;
            r_o_count   <= r_count;
        end
    end

    assign o_stat.need_read = n_need_read;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_removed_value = r_o_removed;
    assign o_front_value   = r_o_front;
    assign o_back_value    = r_o_back;
    assign o_entry_count   = r_o_count;
    assign o_is_empty      = (r_o_count == '0);

    // Expected free slot, from the front index and the count.
    logic [CNT_W:0]   w_ring_sum;
    logic [IDX_W-1:0] w_tail_chk;

    assign w_ring_sum = (CNT_W+1)'(r_first) + (CNT_W+1)'(r_count);
    assign w_tail_chk = (w_ring_sum >= (CNT_W+1)'(DEPTH))
                        ? IDX_W'(w_ring_sum - (CNT_W+1)'(DEPTH))
                        : IDX_W'(w_ring_sum);

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond capacity");

    // The back pointer always agrees with the front pointer and the count.
    a_tail_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail == w_tail_chk)
        else $error("ring pointers out of step with the count");

    // A clear leaves an empty ring at slot zero.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (r_kind == KIND_CLEAR) |=> (r_count == '0) && (r_first == '0))
        else $error("clear did not empty the ring");

endmodule

### rtl/dque_ctrl.sv
// Controller state machine of the double-ended queue.
module dque_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dque_pkg::t_dp_stat i_stat,
    output dque_pkg::t_dp_cmd  o_cmd
);
    import dque_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] r_state, n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state          = r_state;
        o_in_ready       = 1'b0;
        o_cmd.capture    = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.rd_capture = 1'b0;
        o_cmd.load_out   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.need_read ? S_READ : S_DONE;
            end
            S_READ: begin
                o_cmd.rd_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                // Wait until the result register can take the new result.
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // At most one datapath command is issued per cycle.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.exec, o_cmd.rd_capture, o_cmd.load_out}))
        else $error("several datapath commands at once");

    // A result is only loaded when the result register is free.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_stat.out_free)
        else $error("result register overwritten");

    // Execution is followed by the memory refill or the result stage.
    a_exec_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> (r_state == S_READ) || (r_state == S_DONE))
        else $error("unexpected state after execution");

endmodule

### rtl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Usage: requests arrive on i_in (valid/ready), each carrying a kind (push
// front, push back, pop front, pop back, clear, query) and a value used by
// the pushes. Every accepted transaction yields exactly one result on o_out:
// status (ok, overflow, underflow), the popped value, both end values, the
// entry count and an empty flag, all describing the queue after the request.
//
// Timing: a request is accepted in the idle state, executed in the next
// cycle and, for a pop that leaves entries behind, followed by a read
// state in which the new end value is fetched through the registered
// memory read port. The result is then loaded in the done state once the
// result register is free, and the block takes no new request until it
// has loaded the result of the last one, since it handles one request at
// a time around the registered memory read.
//
// Reset empties the queue (front at slot zero, count zero) and drops any
// pending result; slot contents are not cleared. While the receiver holds
// ready low the result register keeps its transaction, the next request is
// still accepted and executed, and it waits until the register frees.
module double_ended_queue #(
    parameter  int DEPTH = dque_pkg::DEPTH_DEFAULT,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dque_in_if.sink     i_in,
    dque_out_if.source  o_out
);
    import dque_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    logic [CNT_W-1:0] w_entry_count;

    // Sequencing of each request.
    dque_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Ring storage and result register.
    dque_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_kind          (i_in.kind),
        .i_value         (i_in.value),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_status        (o_out.status),
        .o_removed_value (o_out.removed_value),
        .o_front_value   (o_out.front_value),
        .o_back_value    (o_out.back_value),
        .o_entry_count   (w_entry_count),
        .o_is_empty      (o_out.is_empty)
    );

    assign o_out.entry_count = w_entry_count;

endmodule

### dv/dque_checker.sv
`timescale 1ns / 1ps
// Checker for the double-ended queue: predicts each result and compares the result channel.
module dque_checker #(
    parameter int DEPTH = dque_pkg::DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dque_in_if   i_req,
    dque_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_overflows,
    output int   o_underflows,
    output int   o_full_hits
);
    import dque_pkg::*;

    // One result transaction as the block should present it.
    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] removed_value;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
    } t_deque_result;

    // Shadow copy of the ring and its pointers.
    logic [DATA_W-1:0] shadow_ring [DEPTH];
    int unsigned       shadow_head;
    int unsigned       shadow_fill;

    t_deque_result results_due[$];
    t_deque_result want;
    t_deque_result got;

    int fail_total;
    int checked_total;
    int overflow_total;
    int underflow_total;
    int full_total;

    // Apply one request to the shadow queue and return the result it must produce.
    function automatic t_deque_result apply_request(input logic [KIND_W-1:0] kind,
                                                    input logic [DATA_W-1:0] value);
        t_deque_result res;
        res = '0;
        case (kind)
            KIND_PUSH_FRONT: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = STATUS_OVERFLOW;
                end else begin
                    shadow_head              = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_ring[shadow_head] = value;
                    shadow_fill++;
                end
            end
            KIND_PUSH_BACK: begin
                if (shadow_fill >= DEPTH) begin
                    res.status = STATUS_OVERFLOW;
                end else begin
                    shadow_ring[(shadow_head + shadow_fill) % DEPTH] = value;
                    shadow_fill++;
                end
            end
            KIND_POP_FRONT: begin
                if (shadow_fill == 0) begin
                    res.status = STATUS_UNDERFLOW;
                end else begin
                    res.removed_value = shadow_ring[shadow_head];
                    shadow_head       = (shadow_head + 1) % DEPTH;
                    shadow_fill--;
                end
            end
            KIND_POP_BACK: begin
                if (shadow_fill == 0) begin
                    res.status = STATUS_UNDERFLOW;
                end else begin
                    res.removed_value = shadow_ring[(shadow_head + shadow_fill - 1) % DEPTH];
                    shadow_fill--;
                end
            end
            KIND_CLEAR: begin
                shadow_fill = 0;
                shadow_head = 0;
            end
            default: begin
                // A query, or one of the unused kinds, leaves the queue alone.
            end
        endcase
        if (shadow_fill != 0) begin
            res.front_value = shadow_ring[shadow_head];
            res.back_value  = shadow_ring[(shadow_head + shadow_fill - 1) % DEPTH];
        end
        res.entry_count = CNT_W'(shadow_fill);
        res.is_empty    = (shadow_fill == 0);
        return res;
    endfunction

    // Predict on every accepted request and check every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_head = 0;
            shadow_fill = 0;
            results_due.delete();
        end else begin
            if (i_req.valid && i_req.ready) begin
                want = apply_request(i_req.kind, i_req.value);
                results_due = {results_due, want};
                if (want.status == STATUS_OVERFLOW)  overflow_total++;
                if (want.status == STATUS_UNDERFLOW) underflow_total++;
                if (shadow_fill == DEPTH)            full_total++;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.status        = i_rsp.status;
                got.removed_value = i_rsp.removed_value;
                got.front_value   = i_rsp.front_value;
                got.back_value    = i_rsp.back_value;
                got.entry_count   = i_rsp.entry_count;
                got.is_empty      = i_rsp.is_empty;
                checked_total++;
                if (results_due.size() == 0) begin
                    if (fail_total < 10)
                        $display({"%0t: result transaction with none outstanding: ",
                                  "st=%0d rm=%0d fr=%0d bk=%0d n=%0d e=%0b"},
                                 $time, got.status, got.removed_value, got.front_value,
                                 got.back_value, got.entry_count, got.is_empty);
                    fail_total++;
                end else begin
                    want = results_due[0];
                    results_due.delete(0);
                    if (got !== want) begin
                        if (fail_total < 10) begin
                            $display({"%0t: mismatch, expected ",
                                      "st=%0d rm=%0d fr=%0d bk=%0d n=%0d e=%0b"},
                                     $time, want.status, want.removed_value,
                                     want.front_value, want.back_value,
                                     want.entry_count, want.is_empty);
                            $display({"%0t:           actual   ",
                                      "st=%0d rm=%0d fr=%0d bk=%0d n=%0d e=%0b"},
                                     $time, got.status, got.removed_value,
                                     got.front_value, got.back_value,
                                     got.entry_count, got.is_empty);
                        end
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= results_due.size();
        o_checked    <= checked_total;
        o_overflows  <= overflow_total;
        o_underflows <= underflow_total;
        o_full_hits  <= full_total;
    end

    initial begin
        shadow_head     = 0;
        shadow_fill     = 0;
        fail_total      = 0;
        checked_total   = 0;
        overflow_total  = 0;
        underflow_total = 0;
        full_total      = 0;
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Top of the double-ended queue testbench: clock, reset, stimulus, receiver and verdict.
module tb;
    import dque_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 1270;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int SETTLE_TICKS = 12;

    // Kinds the block does not define; they must behave as a query.
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    // Traffic shapes for the random part.
    typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIXED } t_traffic_mode;

    logic i_clk;
    logic i_rst_n;

    dque_in_if                   req_ch ();
    dque_out_if #(.CNT_W(CNT_W)) rsp_ch ();

    double_ended_queue #(.DEPTH(DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    int fail_count;
    int pending;
    int checked;
    int overflows;
    int underflows;
    int full_hits;

    dque_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_overflows  (overflows),
        .o_underflows (underflows),
        .o_full_hits  (full_hits)
    );

    int requests_sent;
    int hold_asked;
    int hold_served;
    int idle_ticks;

    // Clock generation.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog: ends the run when no transaction moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_ticks = 0;
        end else begin
            idle_ticks++;
            if (idle_ticks >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without a transaction", STALL_LIMIT);
                $display("[double_ended_queue] ERROR");
                $finish;
            end
        end
    end

    // Offer one request and hold it until the block takes it.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value);
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        do @(posedge i_clk); while (!req_ch.ready);
        requests_sent++;
    endtask

    // Drop valid for a number of cycles, with junk on the payload meanwhile.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            req_ch.valid <= 1'b0;
            req_ch.kind  <= KIND_W'($urandom_range(0, 7));
            req_ch.value <= $urandom;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every outstanding result has come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Values lean towards the extremes of the signed range.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Pick a request kind; the mode sets the balance between pushes and pops.
    function automatic logic [KIND_W-1:0] pick_kind(input t_traffic_mode mode);
        int roll;
        int push_pct;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  push_pct = 85;
            MODE_DRAIN: push_pct = 15;
            default:    push_pct = 50;
        endcase
        if (roll < 1) return KIND_CLEAR;
        if (roll < 4) return KIND_QUERY;
        if (roll < 5) return $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
    endfunction

    // Receiver: random ready patterns in stretches, plus a long hold-off on request.
    initial begin
        int style;
        int span;
        int tick;
        rsp_ch.ready <= 1'b0;
        forever begin
            if (hold_served < hold_asked) begin
                @(posedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served++;
                rsp_ch.ready <= 1'b1;
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(8, 48);
                for (tick = 0; tick < span; tick++) begin
                    @(posedge i_clk);
                    case (style)
                        0:       rsp_ch.ready <= 1'b1;
                        1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                        2:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                        default: rsp_ch.ready <= ((tick % 5) < 2);
                    endcase
                end
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        t_traffic_mode        mode;
        logic [KIND_W-1:0]    kind;
        int                   random_sent;
        int                   burst;
        int                   i;
        bit                   hold_done;
        int                   next_drain;
        requests_sent = 0;
        hold_asked    = 0;
        hold_served   = 0;
        idle_ticks    = 0;
        random_sent   = 0;
        hold_done     = 1'b0;
        next_drain    = 300;
        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= KIND_QUERY;
        req_ch.value <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty queue, extremes, clear, wrap of the front, full queue.
        send_request(KIND_QUERY, 32'sh0);
        send_request(KIND_POP_FRONT, 32'sh1234_5678);
        send_request(KIND_POP_BACK, -32'sd1);
        send_request(KIND_PUSH_FRONT, 32'sh8000_0000);
        send_request(KIND_PUSH_BACK, 32'sh7fff_ffff);
        send_request(KIND_CLEAR, 32'sh0);
        for (i = 0; i < DEPTH; i++)
            send_request(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT,
                         i[0] ? -(i + 1) : 32'sh7fff_0000 + i);
        send_request(KIND_PUSH_FRONT, -32'sd1);
        send_request(KIND_PUSH_BACK, 32'sh8000_0000);
        send_request(KIND_SPARE_LO, 32'sh5555_5555);
        send_request(KIND_SPARE_HI, 32'shaaaa_aaaa);
        send_request(KIND_POP_BACK, 32'sh0);
        send_request(KIND_POP_FRONT, 32'sh0);
        idle_sender($urandom_range(1, 6));

        // Random part in bursts, with a long receiver hold-off and a few full drains.
        while (random_sent < RANDOM_ITEMS) begin
            if (!hold_done && random_sent >= 600) begin
                // Keep offering while the receiver holds off, so the block backs up.
                hold_asked++;
                for (i = 0; i < 30; i++)
                    send_request(pick_kind(MODE_FILL), pick_value());
                random_sent += 30;
                hold_done = 1'b1;
            end
            if (random_sent >= next_drain) begin
                drain_results();
                idle_sender($urandom_range(1, 4));
                next_drain += 400;
            end
            mode  = t_traffic_mode'($urandom_range(0, 2));
            burst = $urandom_range(1, 40);
            for (i = 0; i < burst; i++) begin
                kind = pick_kind(mode);
                send_request(kind, pick_value());
                if (kind != KIND_SPARE_LO && kind != KIND_SPARE_HI)
                    random_sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 12));
        end

        drain_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d results.", requests_sent, checked);
        $display("Saw %0d overflows, %0d underflows and a full queue %0d times.",
                 overflows, underflows, full_hits);
        if (fail_count == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("%0d result transactions failed", fail_count);
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/dque_pkg.sv
rtl/dque_in_if.sv
rtl/dque_out_if.sv
rtl/dque_dp.sv
rtl/dque_ctrl.sv
rtl/double_ended_queue.sv
dv/dque_checker.sv
dv/tb.sv
